### src/disk_arm_stepper_phase_tracker_macros.svh
// Assertion macros for the head-arm stepper tracker.
// Used by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef DISK_ARM_STEPPER_PHASE_TRACKER_MACROS_SVH
`define DISK_ARM_STEPPER_PHASE_TRACKER_MACROS_SVH

// check on every clock edge outside reset
`define DASP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define DASP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/dasp_pkg.sv
// Types, constants and the magnet-to-phase lookup of the head-arm stepper tracker.
// No dependencies.
package dasp_pkg;

  localparam int unsigned QtWidth     = 8;
  localparam int unsigned SettleWidth = 16;
  localparam logic [SettleWidth-1:0] SettleReset = 16'd1000;

  typedef enum logic [0:0] {
    REQ_TICK   = 1'b0,
    REQ_MAGNET = 1'b1
  } dasp_req_e;

  typedef struct packed {
    dasp_req_e   req_type;
    logic [1:0]  phase_index;
    logic        phase_on;
  } dasp_in_t;

  typedef struct packed {
    logic [QtWidth-1:0] quarter_track;
    logic [2:0]         cog_phase;
    logic [3:0]         magnet_mask;
    logic               move_pending;
  } dasp_out_t;

  typedef struct packed {
    logic [3:0]             magnets;
    logic [2:0]             rotor_phase;
    logic [3:0]             target_phase;   // bit 3: no pull
    logic [SettleWidth-1:0] settle_count;
    logic [QtWidth-1:0]     head_position;
  } dasp_state_t;

  localparam logic [3:0] NoPull = 4'b1000;

  // Cog phase pulled toward by a magnet pattern.
  function automatic logic [3:0] pull_phase(input logic [3:0] mask);
    logic [3:0] res;
    case (mask)
      4'd1:    res = 4'd0;
      4'd2:    res = 4'd2;
      4'd3:    res = 4'd1;
      4'd4:    res = 4'd4;
      4'd6:    res = 4'd3;
      4'd7:    res = 4'd2;
      4'd8:    res = 4'd6;
      4'd9:    res = 4'd7;
      4'd11:   res = 4'd0;
      4'd12:   res = 4'd5;
      4'd13:   res = 4'd6;
      4'd14:   res = 4'd4;
      default: res = NoPull;  // none, opposite pairs, all on
    endcase
    return res;
  endfunction

endpackage

### src/dasp_step.sv
// Next-state and result logic for one item of the head-arm stepper tracker.
// Depends on dasp_pkg.
module dasp_step import dasp_pkg::*; #(
  parameter int unsigned TRACK_QUARTERS = 160
) (
  input  dasp_state_t            state_i,
  input  dasp_in_t               item_i,
  input  logic [SettleWidth-1:0] settle_ticks_i,
  output dasp_state_t            state_o,
  output dasp_out_t              result_o
);

  localparam logic signed [QtWidth+1:0] LastPos = (QtWidth+2)'(TRACK_QUARTERS - 1);

  logic [3:0]                 mask_new;
  logic [SettleWidth-1:0]     cnt_dec;
  logic [2:0]                 diff;
  logic signed [3:0]          delta;
  logic signed [QtWidth+1:0]  pos;
  logic [QtWidth-1:0]         head_clamped;

  always_comb begin
    mask_new = state_i.magnets;
    mask_new[item_i.phase_index] = item_i.phase_on;
  end

  assign cnt_dec = state_i.settle_count - SettleWidth'(1);

  // shortest wrapped difference; opposite phase gives no head move
  assign diff = state_i.target_phase[2:0] - state_i.rotor_phase;
  always_comb begin
    if (!diff[2]) begin
      delta = {1'b0, diff};
    end else if (diff == 3'd4) begin
      delta = 4'sd0;
    end else begin
      delta = {1'b1, diff};
    end
  end

  assign pos = $signed({2'b00, state_i.head_position}) + {{(QtWidth-2){delta[3]}}, delta};

  always_comb begin
    if (pos < 0) begin
      head_clamped = '0;
    end else if (pos > LastPos) begin
      head_clamped = LastPos[QtWidth-1:0];
    end else begin
      head_clamped = pos[QtWidth-1:0];
    end
  end

  always_comb begin
    state_o = state_i;
    if (item_i.req_type == REQ_MAGNET) begin
      state_o.magnets      = mask_new;
      state_o.target_phase = pull_phase(mask_new);
      state_o.settle_count = settle_ticks_i;
    end else if (state_i.settle_count != '0) begin
      state_o.settle_count = cnt_dec;
      if (cnt_dec == '0 && !state_i.target_phase[3]) begin
        state_o.head_position = head_clamped;
        state_o.rotor_phase   = state_i.target_phase[2:0];
      end
    end
  end

  assign result_o.quarter_track = state_o.head_position;
  assign result_o.cog_phase     = state_o.rotor_phase;
  assign result_o.magnet_mask   = state_o.magnets;
  assign result_o.move_pending  = (state_o.settle_count != '0);

endmodule

### src/disk_arm_stepper_phase_tracker.sv
// Top level of the head-arm stepper tracker: input register, state, result register.
// Depends on dasp_pkg, dasp_step and disk_arm_stepper_phase_tracker_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o   | in_data_i  (dasp_in_t)
//  out     | from block| out_valid_o / out_stall_i | out_data_o (dasp_out_t)
//  cfg     | to block  | cfg_we_i                  | cfg_wdata_i (settle_ticks)
//
// Every item gives one result, through the input register, the state update and then the
// result register. One item per cycle is sustained while the output does not stall, set by
// the single state update pass between the two registers. Reset is asynchronous, active low,
// and takes effect at once: magnets, cog phase, target and countdown clear, the head sits at
// mid disk, settle_ticks returns to 1000. A stall on the output holds the result register and
// the input register; the input stalls only when both are full.
`include "disk_arm_stepper_phase_tracker_macros.svh"

module disk_arm_stepper_phase_tracker import dasp_pkg::*; #(
  parameter int unsigned TRACK_QUARTERS = 160
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  dasp_in_t               in_data_i,
  // result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dasp_out_t              out_data_o,
  // settle_ticks register
  input  logic                   cfg_we_i,
  input  logic [SettleWidth-1:0] cfg_wdata_i
);

  localparam logic [QtWidth-1:0] HeadReset = QtWidth'(TRACK_QUARTERS >> 1);

  // input register
  logic        in_valid_q, in_valid_d;
  dasp_in_t    in_data_q;

  // result register
  logic        out_valid_q, out_valid_d;
  dasp_out_t   out_data_q;

  // tracker state and the settle time register
  dasp_state_t            state_q, state_d;
  logic [SettleWidth-1:0] settle_ticks_q;

  dasp_out_t   result;
  logic        advance;   // result register may load
  logic        in_xfer;   // input transfer this cycle
  logic        commit;    // item in input register updates state now

  assign advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign commit = in_valid_q && advance;

  always_comb begin
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  dasp_step #(
    .TRACK_QUARTERS(TRACK_QUARTERS)
  ) u_step (
    .state_i        (state_q),
    .item_i         (in_data_q),
    .settle_ticks_i (settle_ticks_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
      settle_ticks_q         <= SettleReset;
      state_q.magnets        <= '0;
      state_q.rotor_phase    <= '0;
      state_q.target_phase   <= '0;
      state_q.settle_count   <= '0;
      state_q.head_position  <= HeadReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        settle_ticks_q <= cfg_wdata_i;
      end
      if (commit) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (commit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // state moves only when an item goes through
  `DASP_ASSERT(a_state_holds, !commit |=> $stable(state_q), "state changed without an item")
  // the result shown matches the state it came from
  `DASP_ASSERT(a_result_head, commit |=> out_valid_q && out_data_q.quarter_track == state_q.head_position && out_data_q.cog_phase == state_q.rotor_phase, "result and state disagree")
  // one step of the cog moves the head by at most three quarter tracks
  `DASP_ASSERT(a_head_step, commit |=> ({1'b0, state_q.head_position} <= {1'b0, $past(state_q.head_position)} + 9'd3) && ({1'b0, $past(state_q.head_position)} <= {1'b0, state_q.head_position} + 9'd3), "head jumped too far")
  // the head never leaves the disk
  `DASP_ASSERT_ALWAYS(a_head_range, !rst_ni || (32'(state_q.head_position) <= TRACK_QUARTERS - 1), "head off the disk")

endmodule

### verif/disk_arm_stepper_phase_tracker_tb.sv
// Self-checking testbench for the head-arm stepper tracker: directed magnet patterns, then
// random seek sequences checked against an in-bench model of magnets, cog and head.
// Depends on dasp_pkg and the disk_arm_stepper_phase_tracker RTL.
`timescale 1ns / 1ps

module disk_arm_stepper_phase_tracker_tb;
  import dasp_pkg::*;

  localparam int Quarters = 160;        // disk size given to the block
  localparam int unsigned IdlePct = 30; // chance of a bubble / stall per cycle
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned HoldEvery = 600;

  // Cog phase that each magnet pattern pulls toward; NoPull for none.
  localparam logic [3:0] PullOf [16] = '{
    NoPull, 4'd0, 4'd2, 4'd1, 4'd4, NoPull, 4'd3, 4'd2,
    4'd6, 4'd7, NoPull, 4'd0, 4'd5, 4'd6, 4'd4, NoPull
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  dasp_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  dasp_out_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [SettleWidth-1:0] cfg_wdata = '0;

  disk_arm_stepper_phase_tracker #(
    .TRACK_QUARTERS(Quarters)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Arm model: own copy of the register and of the block's state.
  // ---------------------------------------------------------------------------
  logic [SettleWidth-1:0] arm_settle = SettleReset;
  logic [3:0]             arm_magnets = '0;
  logic [2:0]             arm_rotor = '0;
  logic [3:0]             arm_target = '0;   // bit 3 set: pattern pulls nowhere
  logic [SettleWidth-1:0] arm_count = '0;
  logic [QtWidth-1:0]     arm_head = QtWidth'(Quarters / 2);

  // statistics for the summary only
  int unsigned n_moves = 0;
  int unsigned n_opposite = 0;
  int unsigned n_floor = 0;
  int unsigned n_ceiling = 0;

  // Applies one item to the model and returns the status the block must report.
  function automatic dasp_out_t advance_arm(input dasp_in_t it);
    int         pos;
    logic [2:0] phase_gap;
    dasp_out_t  res;
    if (it.req_type == REQ_MAGNET) begin
      // any write re-arms the countdown, even one that changes nothing
      arm_magnets[it.phase_index] = it.phase_on;
      arm_target = PullOf[arm_magnets];
      arm_count = arm_settle;
    end else if (arm_count != '0) begin
      arm_count = arm_count - 1'b1;
      if (arm_count == '0 && !arm_target[3]) begin
        // shortest signed step; exactly half a turn leaves the head alone
        phase_gap = arm_target[2:0] - arm_rotor;
        pos = int'(arm_head);
        if (phase_gap == 3'd4) n_opposite++;
        else if (phase_gap < 3'd4) pos = pos + int'(phase_gap);
        else pos = pos - (8 - int'(phase_gap));
        if (pos <= 0) begin
          pos = 0;
          n_floor++;
        end else if (pos >= Quarters - 1) begin
          pos = Quarters - 1;
          n_ceiling++;
        end
        arm_head = QtWidth'(pos);
        arm_rotor = arm_target[2:0];
        n_moves++;
      end
    end
    res.quarter_track = arm_head;
    res.cog_phase = arm_rotor;
    res.magnet_mask = arm_magnets;
    res.move_pending = (arm_count != '0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and shared flags
  // ---------------------------------------------------------------------------
  dasp_in_t    pending_q[$];   // items not yet offered to the block
  dasp_out_t   status_q[$];    // expected status, oldest first
  dasp_out_t   want;
  bit          in_took = 1'b0; // an input transfer happened at the last rising edge
  bit          calm = 1'b0;    // no random bubbles or stalls on either side
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_errors = 0;
  int unsigned n_cfg = 0;
  int unsigned n_holds = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 200;
  int unsigned quiet = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp);
    $display("MISMATCH at result %0d: %s got %0d expected %0d", n_out, what, got, exp);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each output transfer.
  // Prediction runs first so a same-edge result would still find its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        status_q.push_back(advance_arm(in_data));
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (status_q.size() == 0) begin
          report_mismatch("unrequested status word", 32'(out_data), 0);
        end else begin
          want = status_q.pop_front();
          if (out_data.quarter_track !== want.quarter_track)
            report_mismatch("quarter_track", 32'(out_data.quarter_track),
                            32'(want.quarter_track));
          if (out_data.cog_phase !== want.cog_phase)
            report_mismatch("cog_phase", 32'(out_data.cog_phase), 32'(want.cog_phase));
          if (out_data.magnet_mask !== want.magnet_mask)
            report_mismatch("magnet_mask", 32'(out_data.magnet_mask),
                            32'(want.magnet_mask));
          if (out_data.move_pending !== want.move_pending)
            report_mismatch("move_pending", 32'(out_data.move_pending),
                            32'(want.move_pending));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: a held item stays put until its transfer; bubbles are random and
  // never look at the stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (rst_n && pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off every HoldEvery results so
  // the block backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (n_out >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles - 1;
      next_hold_at <= next_hold_at + HoldEvery;
      n_holds++;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d status words outstanding",
               QuietLimit, status_q.size());
      $display("disk_arm_stepper_phase_tracker_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own rough idea of the magnet
  // mask and cog phase to build step sequences; the model above is the truth.
  // ---------------------------------------------------------------------------
  logic [3:0]  gen_mask = '0;
  logic [2:0]  gen_phase = '0;
  int unsigned settle_now = SettleReset;
  int unsigned n_gen = 0;

  // a tick carries random magnet fields, which the block must ignore
  task automatic push_tick();
    dasp_in_t it;
    it.req_type = REQ_TICK;
    it.phase_index = $urandom_range(3);
    it.phase_on = $urandom_range(1);
    pending_q.push_back(it);
    n_gen++;
  endtask

  task automatic push_ticks(input int unsigned cnt);
    repeat (cnt) push_tick();
  endtask

  task automatic push_write(input int unsigned idx, input bit on);
    dasp_in_t it;
    it.req_type = REQ_MAGNET;
    it.phase_index = idx[1:0];
    it.phase_on = on;
    gen_mask[idx] = on;
    pending_q.push_back(it);
    n_gen++;
  endtask

  // Waits until the block has nothing in flight, then a short settling pause.
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_settle(input logic [SettleWidth-1:0] ticks);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    arm_settle = ticks;
    settle_now = ticks;
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One well-formed step of k phases in direction dir: flip the magnets to the
  // pattern that pulls to the new phase, then tick out the settle time. A few
  // steps are broken off early: one magnet only, or too few ticks.
  task automatic seek_step(input int dir, input int unsigned k);
    logic [2:0]  goal;
    logic [1:0]  lo;
    logic [3:0]  want_mask;
    int unsigned first;
    int unsigned idx;
    bit          partial;
    bit          short_wait;
    goal = 3'(int'(gen_phase) + dir * int'(k));
    lo = goal[2:1];
    if (goal[0]) want_mask = (4'b0001 << lo) | (4'b0001 << 2'(lo + 2'd1));
    else want_mask = 4'b0001 << lo;
    partial = ($urandom_range(99) < 8);
    short_wait = ($urandom_range(99) < 6);
    first = $urandom_range(3);
    for (int j = 0; j < 4; j++) begin
      idx = (first + j) % 4;
      if (gen_mask[idx] != want_mask[idx]) begin
        push_write(idx, want_mask[idx]);
        if (partial) break;
        if ($urandom_range(99) < 10) push_tick();
      end
    end
    if (short_wait) begin
      push_ticks($urandom_range(settle_now - 1));
    end else begin
      push_ticks(settle_now + $urandom_range(2));
      if (!partial) gen_phase = goal;
    end
  endtask

  function automatic int unsigned pick_stride();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 4;
    if (r < 20) return 1;
    if (r < 50) return 2;
    return 3;
  endfunction

  task automatic seek_burst(input int dir, input int unsigned steps);
    repeat (steps) seek_step(dir, pick_stride());
  endtask

  task automatic noise(input int unsigned cnt);
    repeat (cnt) begin
      if ($urandom_range(1) != 0) push_tick();
      else push_write($urandom_range(3), $urandom_range(1));
    end
  endtask

  // mostly seek bursts, about a quarter plain noise
  task automatic random_phase(input int unsigned goal);
    while (n_gen < goal) begin
      if ($urandom_range(3) == 0) noise($urandom_range(1, 8));
      else seek_burst(($urandom_range(1) != 0) ? 1 : -1, $urandom_range(3, 20));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settle time: idle tick, a write, a write during the countdown
    // (restart), then ticks that leave the move pending.
    push_tick();
    push_write(0, 1'b1);
    push_write(1, 1'b1);
    push_ticks(2);

    // Zero settle time: the write arms nothing and the cog never moves.
    set_settle(16'd0);
    push_write(2, 1'b1);
    push_tick();

    // Smallest nonzero settle time: walk through the special patterns.
    set_settle(16'd1);
    push_write(1, 1'b0);   // opposite pair 0+2: no pull
    push_write(2, 1'b0);   // magnet 0 alone
    push_tick();
    push_write(0, 1'b0);   // all off: countdown expires without a pull
    push_tick();
    push_write(2, 1'b1);   // half a turn away: cog moves, head stays
    push_tick();
    push_write(3, 1'b1);   // one step forward
    push_tick();
    push_write(1, 1'b1);
    push_write(3, 1'b0);   // two steps back
    push_tick();
    push_write(0, 1'b1);
    push_write(3, 1'b1);   // all four on: no pull
    push_tick();
    push_write(1, 1'b0);
    push_write(2, 1'b0);   // pattern 0+3, again half a turn away
    push_tick();
    push_tick();           // countdown already idle
    gen_phase = 3'd7;

    // Long seeks to each end stop, then random traffic.
    seek_burst(-1, 50);
    seek_burst(1, 90);
    random_phase(700);

    // A stretch with no bubbles and no random stalls.
    set_settle(16'd3);
    calm = 1'b1;
    random_phase(1000);

    // Largest settle time: moves stay pending, writes keep restarting.
    set_settle(16'hFFFF);
    calm = 1'b0;
    push_write($urandom_range(3), 1'b1);
    push_ticks(10);
    push_write($urandom_range(3), 1'b0);
    push_ticks(20);
    noise(20);

    set_settle(16'd2);
    random_phase(1450);

    drain();
    repeat (10) @(posedge clk);
    $display("ran %0d items, %0d status words, %0d settle writes, %0d output hold-offs",
             n_in, n_out, n_cfg, n_holds);
    $display("cog moved %0d times (%0d half-turn), head hit inner stop %0d, outer stop %0d",
             n_moves, n_opposite, n_floor, n_ceiling);
    if (n_errors == 0) begin
      $display("disk_arm_stepper_phase_tracker_tb OK");
    end else begin
      $display("disk_arm_stepper_phase_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule

### disk_arm_stepper_phase_tracker.f
+incdir+src
src/dasp_pkg.sv
src/dasp_step.sv
src/disk_arm_stepper_phase_tracker.sv
verif/disk_arm_stepper_phase_tracker_tb.sv
